[rtl/dmsr_pkg.sv]
// dmsr_pkg: types and constants shared by the dual motor speed ramp
// no dependencies

package dmsr_pkg;

	typedef enum logic [1:0] {
		PH_WAIT  = 2'd0,
		PH_RUN   = 2'd1,
		PH_END   = 2'd2,
		PH_RETRY = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_RDIV,
		ST_LDIV,
		ST_SYNC,
		ST_RMUL1,
		ST_RMUL2,
		ST_RMUL3,
		ST_RFIN,
		ST_TDIV,
		ST_TFIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_CURVE_MODE   = 3'd0,
		REG_ACCEL_TIME   = 3'd1,
		REG_DECEL_TIME   = 3'd2,
		REG_GEAR_TIME    = 3'd3,
		REG_MIN_STOP     = 3'd4,
		REG_BUMPER       = 3'd5,
		REG_FULL_SCALE   = 3'd6,
		REG_FAST_OOS     = 3'd7
	} reg_idx_t;

	localparam int unsigned CHANNELS = 2;
	localparam int unsigned SPEED_W = 24;
	localparam int unsigned RATE_W  = 32;
	localparam int unsigned DIV_W   = 64;
	localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
	localparam logic [9:0]  TICKS_PER_S = 10'd1000;

endpackage

[rtl/dual_motor_speed_ramp.sv]
// dual_motor_speed_ramp: two-channel speed ramp, one tick item in, one command item out
// depends on dmsr_pkg
// a ramp start runs two 64-step serial divides, a run tick forms three products on the shared multiplier
// (one when curve_mode is clear), a retry tick runs a serial divide by ten; other ticks go straight to output
// handshake: one item at a time; the next can be accepted in the cycle after the result registers
// reset: arst_n clears all channel state and loads the register defaults

module dual_motor_speed_ramp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // target_speed[23:0]
	input  logic [1:0]  s_tuser,   // channel, sync_request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // speed_command[23:0], ramp_phase[25:24], pad
	output logic [1:0]  m_tuser,   // out_channel, sync_active
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	localparam int CW = $clog2(dmsr_pkg::CHANNELS);

	// configuration registers
	logic        curve_mode_q, fast_oos_q;
	logic [15:0] accel_q, decel_q, gear_q, min_stop_q;
	logic [22:0] bumper_q, full_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= 1'b0;
			accel_q      <= 16'd1024;
			decel_q      <= 16'd230;
			gear_q       <= 16'd819;
			min_stop_q   <= 16'd192;
			bumper_q     <= 23'd7680;
			full_scale_q <= 23'd537600;
			fast_oos_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (dmsr_pkg::reg_idx_t'(cfg_index))
				dmsr_pkg::REG_CURVE_MODE: curve_mode_q <= cfg_data[0];
				dmsr_pkg::REG_ACCEL_TIME: accel_q      <= cfg_data[15:0];
				dmsr_pkg::REG_DECEL_TIME: decel_q      <= cfg_data[15:0];
				dmsr_pkg::REG_GEAR_TIME:  gear_q       <= cfg_data[15:0];
				dmsr_pkg::REG_MIN_STOP:   min_stop_q   <= cfg_data[15:0];
				dmsr_pkg::REG_BUMPER:     bumper_q     <= cfg_data;
				dmsr_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data;
				dmsr_pkg::REG_FAST_OOS:   fast_oos_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per channel state
	dmsr_pkg::phase_t   phase_q [dmsr_pkg::CHANNELS];
	logic signed [23:0] cmd_q [dmsr_pkg::CHANNELS], ramp_q [dmsr_pkg::CHANNELS];
	logic signed [23:0] end_q [dmsr_pkg::CHANNELS];
	logic signed [23:0] lat_q [dmsr_pkg::CHANNELS];
	logic [23:0]        span_q [dmsr_pkg::CHANNELS];
	logic               fall_q [dmsr_pkg::CHANNELS], brake_q [dmsr_pkg::CHANNELS];
	logic               cross_q [dmsr_pkg::CHANNELS];
	logic [31:0]        rate_q [dmsr_pkg::CHANNELS], prog_q [dmsr_pkg::CHANNELS];
	logic [31:0]        step_q [dmsr_pkg::CHANNELS], retry_q [dmsr_pkg::CHANNELS];
	logic               sync_q;
	logic [1:0]         scount_q;

	// item registers
	dmsr_pkg::state_t   state_q, state_d;
	logic [CW-1:0]      ch_q;
	logic signed [23:0] tgt_q;
	logic [CW-1:0]      oth;
	assign oth = ch_q ^ CW'(1);

	// serial divider: remainder/quotient shift register, one bit per cycle
	logic [63:0] num_q, den_q, quo_q;
	logic [64:0] rem_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_sh;
	logic        rem_ge;
	assign rem_sh = {rem_q[63:0], num_q[63]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	// shared multiplier
	logic [33:0] ma_q;
	logic [31:0] mb_q;
	logic [65:0] mp_q;
	logic [65:0] prod;
	assign prod = 66'(ma_q) * 66'(mb_q);

	logic [15:0] time_q;
	logic [31:0] lim_q, rate_s;
	logic [15:0] tsel;

	// output register
	logic        ov_q;
	logic [23:0] ocmd_q;
	logic [1:0]  oph_q;
	logic        och_q, osync_q;
	logic        out_free;

	assign out_free = !ov_q || m_tready;
	assign s_tready = (state_q == dmsr_pkg::ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, oph_q, ocmd_q};
	assign m_tuser  = {osync_q, och_q};

	// chosen ramp time and direction flags for a ramp start
	logic signed [23:0] c0, c1, cc;
	logic               same, gear, brk_n, crs_n;
	logic [15:0]        up_t, dn_t;
	always_comb begin
		c0 = cmd_q[0];
		c1 = cmd_q[1];
		cc = cmd_q[ch_q];
		same = (c0 > 0 && c1 > 0) || (c0 < 0 && c1 < 0);
		gear = fast_oos_q || (c0 < 0 && c1 > 0) || same;
		up_t = gear ? gear_q : accel_q;
		dn_t = gear ? gear_q : decel_q;
		brk_n = 1'b0;
		crs_n = 1'b0;
		tsel = up_t;
		if (cc < 0) begin
			if (tgt_q > cc) begin
				tsel = dn_t;
				if (tgt_q > 0) crs_n = 1'b1; else brk_n = 1'b1;
			end
		end else if (cc > 0) begin
			if (tgt_q < cc) begin
				tsel = dn_t;
				if (tgt_q < 0) crs_n = 1'b1; else brk_n = 1'b1;
			end
		end else begin
			brk_n = 1'b1;
		end
	end

	logic [15:0] tnz, snz;
	assign tnz = (tsel == 16'd0) ? 16'd1 : tsel;
	assign snz = (min_stop_q == 16'd0) ? 16'd1 : min_stop_q;

	logic signed [23:0] end_n;
	logic               fall_n;
	logic [23:0]        span_n;
	logic [23:0]        mag_n;
	always_comb begin
		end_n  = crs_n ? 24'sd0 : tgt_q;
		fall_n = end_n < cc;
		span_n = fall_n ? 24'(cc - end_n) : 24'(end_n - cc);
		mag_n  = tgt_q[23] ? 24'(-tgt_q) : tgt_q;
	end

	// clamped move of the ramp speed by a magnitude
	function automatic logic signed [23:0] move_f(input logic signed [23:0] r,
		input logic signed [23:0] e, input logic f, input logic [31:0] m);
		logic signed [33:0] v;
		v = f ? 34'(r) - $signed({2'b0, m}) : 34'(r) + $signed({2'b0, m});
		if (f && v < 34'(e)) v = 34'(e);
		if (!f && v > 34'(e)) v = 34'(e);
		return v[23:0];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmsr_pkg::ST_IDLE:  if (s_tvalid && s_tready) state_d = dmsr_pkg::ST_START;
			dmsr_pkg::ST_START: begin
				case (phase_q[ch_q])
					dmsr_pkg::PH_WAIT:  state_d = (cmd_q[ch_q] != tgt_q) ?
						dmsr_pkg::ST_LDIV : dmsr_pkg::ST_OUT;
					dmsr_pkg::PH_RUN:   state_d = dmsr_pkg::ST_RMUL1;
					dmsr_pkg::PH_RETRY: state_d = dmsr_pkg::ST_TDIV;
					default:            state_d = dmsr_pkg::ST_OUT;
				endcase
			end
			dmsr_pkg::ST_LDIV:  if (cnt_q == 7'd64) state_d = dmsr_pkg::ST_RDIV;
			dmsr_pkg::ST_RDIV:  if (cnt_q == 7'd64) state_d = dmsr_pkg::ST_SYNC;
			dmsr_pkg::ST_SYNC:  state_d = dmsr_pkg::ST_OUT;
			dmsr_pkg::ST_RMUL1: state_d = dmsr_pkg::ST_RMUL2;
			dmsr_pkg::ST_RMUL2: state_d = dmsr_pkg::ST_RMUL3;
			dmsr_pkg::ST_RMUL3: state_d = dmsr_pkg::ST_RFIN;
			dmsr_pkg::ST_RFIN:  state_d = dmsr_pkg::ST_OUT;
			dmsr_pkg::ST_TDIV:  if (cnt_q == 7'd32) state_d = dmsr_pkg::ST_TFIN;
			dmsr_pkg::ST_TFIN:  state_d = dmsr_pkg::ST_OUT;
			dmsr_pkg::ST_OUT:   if (out_free) state_d = dmsr_pkg::ST_IDLE;
			default:            state_d = dmsr_pkg::ST_IDLE;
		endcase
	end

	// rate saturation and limits after the rate divide
	always_comb begin
		rate_s = (|quo_q[63:32]) ? dmsr_pkg::RATE_MAX : quo_q[31:0];
		if (span_q[ch_q] == 24'd0) rate_s = dmsr_pkg::RATE_MAX;
		if (rate_s > lim_q && ((brake_q[0] && brake_q[1]) ||
			{1'b0, mag_n} <= {2'b0, bumper_q}))
			rate_s = lim_q;
	end

	logic [31:0] dec;
	assign dec = quo_q[31:0] + ((rem_q[3:0] != 4'd0) ? 32'd1 : 32'd0);

	// datapath and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dmsr_pkg::ST_IDLE;
			ov_q     <= 1'b0;
			sync_q   <= 1'b0;
			scount_q <= 2'd0;
			ch_q     <= '0;
			tgt_q    <= '0;
			num_q    <= '0;
			den_q    <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			ma_q     <= '0;
			mb_q     <= '0;
			mp_q     <= '0;
			time_q   <= '0;
			lim_q    <= '0;
			och_q    <= 1'b0;
			ocmd_q   <= '0;
			oph_q    <= '0;
			osync_q  <= 1'b0;
			for (int i = 0; i < dmsr_pkg::CHANNELS; i++) begin
				phase_q[i] <= dmsr_pkg::PH_WAIT;
				cmd_q[i]   <= '0;
				ramp_q[i]  <= '0;
				end_q[i]   <= '0;
				lat_q[i]   <= '0;
				span_q[i]  <= '0;
				fall_q[i]  <= 1'b0;
				brake_q[i] <= 1'b0;
				cross_q[i] <= 1'b0;
				rate_q[i]  <= '0;
				prog_q[i]  <= '0;
				step_q[i]  <= '0;
				retry_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (ov_q && m_tready) ov_q <= 1'b0;
			case (state_q)
				dmsr_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						ch_q  <= CW'(s_tuser[0]);
						tgt_q <= s_tdata;
						if (s_tuser[1]) sync_q <= 1'b1;
					end
				end
				dmsr_pkg::ST_START: begin
					cnt_q <= '0;
					rem_q <= '0;
					case (phase_q[ch_q])
						dmsr_pkg::PH_WAIT: begin
							// stop limit divide: 2^38 / (1000 * min_stop)
							num_q <= 64'd1 << 38;
							den_q <= 64'(snz) * 64'(dmsr_pkg::TICKS_PER_S);
							time_q <= tnz;
							// ramp setup only when the target differs
							if (cmd_q[ch_q] != tgt_q) begin
								brake_q[ch_q] <= brk_n;
								cross_q[ch_q] <= crs_n;
								ramp_q[ch_q]  <= cc;
								lat_q[ch_q]   <= tgt_q;
								end_q[ch_q]   <= end_n;
								span_q[ch_q]  <= span_n;
								fall_q[ch_q]  <= fall_n;
							end
						end
						dmsr_pkg::PH_RUN: begin
							ma_q <= 34'(prog_q[ch_q]);
							mb_q <= (prog_q[ch_q] > dmsr_pkg::ONE_Q30) ? 32'd0 :
								dmsr_pkg::ONE_Q30 - prog_q[ch_q];
						end
						dmsr_pkg::PH_RETRY: begin
							// ceil(step/10), serial over 32 bits
							num_q <= {step_q[ch_q], 32'd0};
							den_q <= 64'd10;
							cnt_q <= 7'd0;
						end
						default: begin
							cmd_q[ch_q]   <= end_q[ch_q];
							cross_q[ch_q] <= 1'b0;
							phase_q[ch_q] <= dmsr_pkg::PH_WAIT;
							if (end_q[ch_q] == tgt_q) begin
								sync_q   <= 1'b0;
								scount_q <= 2'd0;
							end
						end
					endcase
				end
				dmsr_pkg::ST_LDIV, dmsr_pkg::ST_RDIV, dmsr_pkg::ST_TDIV: begin
					if ((state_q == dmsr_pkg::ST_TDIV) ? cnt_q != 7'd32 : cnt_q != 7'd64) begin
						rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
						quo_q <= {quo_q[62:0], rem_ge};
						num_q <= {num_q[62:0], 1'b0};
						cnt_q <= cnt_q + 7'd1;
					end else if (state_q == dmsr_pkg::ST_LDIV) begin
						lim_q <= quo_q[31:0];
						num_q <= {3'd0, full_scale_q, 38'd0};
						den_q <= 64'(span_q[ch_q]) * 64'(time_q) *
							64'(dmsr_pkg::TICKS_PER_S);
						rem_q <= '0;
						cnt_q <= '0;
					end
				end
				dmsr_pkg::ST_SYNC: begin
					rate_q[ch_q]  <= rate_s;
					phase_q[ch_q] <= dmsr_pkg::PH_RUN;
					prog_q[ch_q]  <= '0;
					if (sync_q && !cross_q[ch_q]) begin
						if (scount_q + 2'd1 == 2'd2) begin
							if (prog_q[oth] != 32'd0) begin
								phase_q[oth] <= dmsr_pkg::PH_WAIT;
								scount_q <= 2'd1;
							end else begin
								logic [31:0] r0, r1, r;
								r0 = (ch_q == CW'(0)) ? rate_s : rate_q[0];
								r1 = (ch_q == CW'(1)) ? rate_s : rate_q[1];
								r  = (r0 < r1) ? r0 : r1;
								if (cmd_q[0] > 0 && cmd_q[1] < 0 && brake_q[0] != brake_q[1]
									&& r > lim_q) r = lim_q;
								if (r != 32'd0) begin
									rate_q[0] <= r;
									rate_q[1] <= r;
								end
								sync_q   <= 1'b0;
								scount_q <= 2'd0;
							end
						end else begin
							scount_q <= scount_q + 2'd1;
						end
					end
				end
				dmsr_pkg::ST_RMUL1: begin
					// f = p(1-p) >> 30, then 6f
					ma_q <= curve_mode_q ? 34'(prod[61:30]) * 34'd6 : 34'(rate_q[ch_q]);
					mb_q <= curve_mode_q ? rate_q[ch_q] : 32'(span_q[ch_q]);
					mp_q <= prod;
				end
				dmsr_pkg::ST_RMUL2: begin
					mp_q <= prod;
					if (curve_mode_q) begin
						ma_q <= prod[63:30];
						mb_q <= 32'(span_q[ch_q]);
					end
				end
				dmsr_pkg::ST_RMUL3: begin
					if (curve_mode_q) mp_q <= prod;
				end
				dmsr_pkg::ST_RFIN: begin
					logic [31:0]        st;
					logic signed [23:0] nr;
					logic [32:0]        sum;
					logic [31:0]        pn;
					dmsr_pkg::phase_t   ph;
					st  = mp_q[61:30];
					nr  = move_f(ramp_q[ch_q], end_q[ch_q], fall_q[ch_q], st);
					sum = 33'(prog_q[ch_q]) + 33'(rate_q[ch_q]);
					pn  = sum[32] ? dmsr_pkg::RATE_MAX : sum[31:0];
					ph  = (pn > dmsr_pkg::ONE_Q30) ? dmsr_pkg::PH_END : dmsr_pkg::PH_RUN;
					if (curve_mode_q) begin
						if (tgt_q != end_q[ch_q] && (tgt_q == 0 || nr == 0 ||
							(tgt_q[23] == nr[23]))) begin
							retry_q[ch_q] <= st;
							ph = dmsr_pkg::PH_RETRY;
						end
					end else if (tgt_q != lat_q[ch_q]) begin
						ph = dmsr_pkg::PH_WAIT;
					end
					step_q[ch_q]  <= st;
					ramp_q[ch_q]  <= nr;
					cmd_q[ch_q]   <= nr;
					prog_q[ch_q]  <= pn;
					phase_q[ch_q] <= ph;
				end
				dmsr_pkg::ST_TFIN: begin
					if (retry_q[ch_q] <= dec) begin
						retry_q[ch_q] <= '0;
						phase_q[ch_q] <= dmsr_pkg::PH_WAIT;
					end else begin
						retry_q[ch_q] <= retry_q[ch_q] - dec;
						ramp_q[ch_q]  <= move_f(ramp_q[ch_q], end_q[ch_q], fall_q[ch_q],
							retry_q[ch_q] - dec);
						cmd_q[ch_q]   <= move_f(ramp_q[ch_q], end_q[ch_q], fall_q[ch_q],
							retry_q[ch_q] - dec);
					end
				end
				dmsr_pkg::ST_OUT: begin
					// load the output register once it is free
					if (out_free) begin
						ov_q    <= 1'b1;
						och_q   <= ch_q[0];
						ocmd_q  <= cmd_q[ch_q];
						oph_q   <= phase_q[ch_q];
						osync_q <= sync_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/dmsr_checker.sv]
// dmsr_checker: port-level checks for the dual motor speed ramp
// depends on dual_motor_speed_ramp (bound to it)

module dmsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// an output item holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// no result appears in the cycle right after an accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("result appeared too early");

	// an accepted item is not followed by an immediate second accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("two items in flight");

endmodule

bind dual_motor_speed_ramp dmsr_checker u_dmsr_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[tb/tb_dual_motor_speed_ramp.sv]
// tb_dual_motor_speed_ramp: checks the dual motor speed ramp against its own predictor of the ramp
// depends on dmsr_pkg and dual_motor_speed_ramp; random stimulus, bursty sender, stalling receiver

typedef struct packed {
	logic        ch;
	logic [23:0] cmd;
	logic [1:0]  ph;
	logic        sync;
} ramp_result_t;

class ramp_scoreboard;
	// register copy
	bit        curve_mode;
	bit [15:0] accel_time, decel_time, gear_time, min_stop_time;
	bit [22:0] bumper_speed, full_scale_speed;
	bit        fast_oos;
	// channel state
	bit [1:0]        phase [2];
	bit signed [31:0] cmd_spd [2], ramp_spd [2], end_spd [2], latched [2];
	bit [31:0] span [2], rate [2], prog [2], step_sz [2], retry_sz [2];
	bit        falling [2], braking [2], crosses [2];
	bit        sync_armed;
	bit [1:0]  sync_count;
	ramp_result_t pending_results[$];
	int errors;

	function new();
		curve_mode = 0; accel_time = 1024; decel_time = 230; gear_time = 819;
		min_stop_time = 192; bumper_speed = 7680; full_scale_speed = 537600;
		fast_oos = 1; sync_armed = 0; sync_count = 0; errors = 0;
		for (int i = 0; i < 2; i++) begin
			phase[i] = dmsr_pkg::PH_WAIT; cmd_spd[i] = 0; ramp_spd[i] = 0; end_spd[i] = 0;
			latched[i] = 0; span[i] = 0; rate[i] = 0; prog[i] = 0; step_sz[i] = 0;
			retry_sz[i] = 0; falling[i] = 0; braking[i] = 0; crosses[i] = 0;
		end
	endfunction

	function void write_reg(dmsr_pkg::reg_idx_t idx, bit [22:0] v);
		case (idx)
			dmsr_pkg::REG_CURVE_MODE: curve_mode = v[0];
			dmsr_pkg::REG_ACCEL_TIME: accel_time = v[15:0];
			dmsr_pkg::REG_DECEL_TIME: decel_time = v[15:0];
			dmsr_pkg::REG_GEAR_TIME:  gear_time = v[15:0];
			dmsr_pkg::REG_MIN_STOP:   min_stop_time = v[15:0];
			dmsr_pkg::REG_BUMPER:     bumper_speed = v;
			dmsr_pkg::REG_FULL_SCALE: full_scale_speed = v;
			dmsr_pkg::REG_FAST_OOS:   fast_oos = v[0];
			default: ;
		endcase
	endfunction

	function bit [63:0] nz(bit [15:0] t);
		return (t == 0) ? 64'd1 : {48'd0, t};
	endfunction

	function bit [31:0] stop_lim();
		bit [63:0] q;
		q = (64'd1 << 38) / (64'd1000 * nz(min_stop_time));
		return q[31:0];
	endfunction

	function bit [31:0] rate_for(bit [31:0] sp, bit [15:0] t);
		bit [63:0] den, q;
		den = {32'd0, sp} * nz(t) * 64'd1000;
		if (den == 0) return dmsr_pkg::RATE_MAX;
		q = ({41'd0, full_scale_speed} << 38) / den;
		return (q > {32'd0, dmsr_pkg::RATE_MAX}) ? dmsr_pkg::RATE_MAX : q[31:0];
	endfunction

	function bit signed [31:0] move_clamped(int c, bit [31:0] mag);
		longint v;
		v = ramp_spd[c];
		if (falling[c]) begin
			v -= mag;
			if (v < end_spd[c]) v = end_spd[c];
		end else begin
			v += mag;
			if (v > end_spd[c]) v = end_spd[c];
		end
		return v[31:0];
	endfunction

	// ramp time by direction, braking and zero crossing
	function bit [15:0] pick_time(int c, bit signed [31:0] tgt);
		bit signed [31:0] c0, c1, cc;
		bit [15:0] up, down;
		bit same;
		c0 = cmd_spd[0]; c1 = cmd_spd[1]; cc = cmd_spd[c];
		same = (c0 > 0 && c1 > 0) || (c0 < 0 && c1 < 0);
		if (fast_oos || (c0 < 0 && c1 > 0) || same) begin
			up = gear_time; down = gear_time;
		end else begin
			up = accel_time; down = decel_time;
		end
		braking[c] = 0; crosses[c] = 0;
		if (cc < 0) begin
			if (tgt <= cc) return up;
			if (tgt > 0) crosses[c] = 1; else braking[c] = 1;
			return down;
		end
		if (cc > 0) begin
			if (tgt >= cc) return up;
			if (tgt < 0) crosses[c] = 1; else braking[c] = 1;
			return down;
		end
		braking[c] = 1;
		return up;
	endfunction

	function void equalize_rates(int c);
		int o;
		bit [31:0] r, lim;
		o = c ^ 1;
		if (!sync_armed || crosses[c]) return;
		sync_count = sync_count + 1;
		if (sync_count != 2) return;
		if (prog[o] != 0) begin
			phase[o] = dmsr_pkg::PH_WAIT;
			sync_count = sync_count - 1;
			return;
		end
		r = (rate[0] < rate[1]) ? rate[0] : rate[1];
		lim = stop_lim();
		if (cmd_spd[0] > 0 && cmd_spd[1] < 0 && braking[0] != braking[1] && r > lim) r = lim;
		if (r != 0) begin
			rate[0] = r; rate[1] = r;
		end
		sync_armed = 0; sync_count = 0;
	endfunction

	function void begin_ramp(int c, bit signed [31:0] tgt);
		bit [15:0] t;
		longint mag;
		bit [31:0] lim;
		t = pick_time(c, tgt);
		mag = (tgt < 0) ? -longint'(tgt) : longint'(tgt);
		lim = stop_lim();
		ramp_spd[c] = cmd_spd[c];
		latched[c] = tgt;
		end_spd[c] = crosses[c] ? 0 : tgt;
		if (end_spd[c] < ramp_spd[c]) begin
			span[c] = ramp_spd[c] - end_spd[c]; falling[c] = 1;
		end else begin
			span[c] = end_spd[c] - ramp_spd[c]; falling[c] = 0;
		end
		rate[c] = rate_for(span[c], t);
		if (rate[c] > lim && ((braking[0] && braking[1]) || mag <= longint'(bumper_speed)))
			rate[c] = lim;
		equalize_rates(c);
		phase[c] = dmsr_pkg::PH_RUN;
		prog[c] = 0;
	endfunction

	function void advance_ramp(int c, bit signed [31:0] tgt);
		bit [63:0] p, q, f, g, st, sum;
		bit signed [31:0] cc;
		bit nonneg;
		p = prog[c];
		if (curve_mode) begin
			q = (p > 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - p;
			f = (p * q) >> 30;
			g = (64'd6 * f * rate[c]) >> 30;
			st = (g * span[c]) >> 30;
		end else begin
			st = ({32'd0, rate[c]} * span[c]) >> 30;
		end
		step_sz[c] = st[31:0];
		ramp_spd[c] = move_clamped(c, step_sz[c]);
		cmd_spd[c] = ramp_spd[c];
		sum = p + rate[c];
		prog[c] = (sum > 64'hFFFF_FFFF) ? dmsr_pkg::RATE_MAX : sum[31:0];
		if (prog[c] > dmsr_pkg::ONE_Q30) phase[c] = dmsr_pkg::PH_END;
		cc = cmd_spd[c];
		if (curve_mode) begin
			nonneg = tgt == 0 || cc == 0 || ((tgt < 0) == (cc < 0));
			if (tgt != end_spd[c] && nonneg) begin
				retry_sz[c] = step_sz[c];
				phase[c] = dmsr_pkg::PH_RETRY;
			end
		end else if (tgt != latched[c]) begin
			phase[c] = dmsr_pkg::PH_WAIT;
		end
	endfunction

	// note an accepted tick item and queue its expected command
	function void note_tick(bit c_bit, bit [23:0] tgt_raw, bit sreq);
		int c;
		bit signed [31:0] tgt;
		bit [31:0] dec;
		ramp_result_t r;
		c = c_bit;
		tgt = {{8{tgt_raw[23]}}, tgt_raw};
		if (sreq) sync_armed = 1;
		case (phase[c])
			dmsr_pkg::PH_WAIT: if (cmd_spd[c] != tgt) begin_ramp(c, tgt);
			dmsr_pkg::PH_RUN: advance_ramp(c, tgt);
			dmsr_pkg::PH_END: begin
				cmd_spd[c] = end_spd[c];
				crosses[c] = 0;
				phase[c] = dmsr_pkg::PH_WAIT;
				if (cmd_spd[c] == tgt) begin
					sync_armed = 0; sync_count = 0;
				end
			end
			default: begin
				dec = step_sz[c] / 10 + ((step_sz[c] % 10) != 0);
				if (retry_sz[c] <= dec) begin
					retry_sz[c] = 0; phase[c] = dmsr_pkg::PH_WAIT;
				end else begin
					retry_sz[c] -= dec;
					ramp_spd[c] = move_clamped(c, retry_sz[c]);
					cmd_spd[c] = ramp_spd[c];
				end
			end
		endcase
		r.ch = c_bit; r.cmd = cmd_spd[c][23:0]; r.ph = phase[c]; r.sync = sync_armed;
		pending_results.push_back(r);
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endfunction

	// compare one command item with the oldest expectation
	function void check_command(ramp_result_t got);
		ramp_result_t w;
		if (pending_results.size() == 0) begin
			report("unexpected item", got, 0);
			return;
		end
		w = pending_results.pop_front();
		if (got.ch !== w.ch) report("out_channel", got.ch, w.ch);
		if (got.cmd !== w.cmd) report("speed_command", got.cmd, w.cmd);
		if (got.ph !== w.ph) report("ramp_phase", got.ph, w.ph);
		if (got.sync !== w.sync) report("sync_active", got.sync, w.sync);
	endfunction
endclass

module tb_dual_motor_speed_ramp;
	logic        clk, arst_n;
	logic        s_tvalid, s_tready, m_tvalid, m_tready;
	logic [23:0] s_tdata;
	logic [31:0] m_tdata;
	logic [1:0]  s_tuser, m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [22:0] cfg_data;

	ramp_scoreboard sb;
	longint cycles;
	int     ticks_sent, results_seen;
	bit     hold_off;
	bit signed [23:0] tgt_now [2];

	dual_motor_speed_ramp u_top (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > 64'd3_000_000) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_dual_motor_speed_ramp: errors");
			$finish;
		end
	end

	// result sampling
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_command({m_tuser[0], m_tdata[23:0], m_tdata[25:24], m_tuser[1]});
			results_seen++;
		end
	end

	// receiver stall pattern
	initial begin
		m_tready = 1'b0;
		hold_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) m_tready <= 1'b0;
			else if (cycles % 300 < 120) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic write_cfg(dmsr_pkg::reg_idx_t idx, bit [22:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one tick item; valid stays high when back to back, else it drops to idle before the task returns
	task automatic send_tick(bit c, bit [23:0] tgt, bit sreq, bit keep);
		s_tvalid <= 1'b1;
		s_tdata <= tgt;
		s_tuser <= {sreq, c};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(c, tgt, sreq);
		ticks_sent++;
		@(negedge clk);
		if (!keep) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic bit [23:0] pick_target();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'd0;
			3: return 24'($urandom);
			default: return 24'($urandom_range(0, 40000) - 20000);
		endcase
	endfunction

	// a run of ticks that chases one target per channel
	task automatic random_phase(int n);
		int burst;
		int gap;
		bit c;
		int i;
		i = 0;
		@(negedge clk);
		while (i < n) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				c = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 19) == 0) tgt_now[c] = pick_target();
				send_tick(c, tgt_now[c], $urandom_range(0, 15) == 0, 1'b1);
				i++;
			end
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		cycles = 0; ticks_sent = 0; results_seen = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		cfg_valid = 0; cfg_index = dmsr_pkg::REG_CURVE_MODE; cfg_data = 0;
		tgt_now[0] = 0; tgt_now[1] = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: small fast ramps, extremes, crossings, sync
		write_cfg(dmsr_pkg::REG_GEAR_TIME, 23'd1);
		write_cfg(dmsr_pkg::REG_ACCEL_TIME, 23'd1);
		write_cfg(dmsr_pkg::REG_DECEL_TIME, 23'd2);
		write_cfg(dmsr_pkg::REG_MIN_STOP, 23'd1);
		@(negedge clk);
		send_tick(0, 24'h7FFFFF, 1, 0);
		send_tick(1, 24'h800000, 0, 0);
		repeat (4) send_tick(0, 24'h7FFFFF, 0, 0);
		repeat (4) send_tick(1, 24'h800000, 0, 0);
		repeat (5) send_tick(0, 24'hFFF000, 0, 0);
		send_tick(1, 24'd0, 1, 0);
		send_tick(0, 24'd0, 0, 0);
		repeat (4) send_tick(1, 24'd0, 0, 0);
		drain();

		// pressure: receiver holds off while the sender keeps offering
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(40);
		join

		// walk through several register settings, extremes among them
		for (int s = 0; s < 6; s++) begin
			drain();
			write_cfg(dmsr_pkg::REG_CURVE_MODE, 23'(s[0]));
			write_cfg(dmsr_pkg::REG_FAST_OOS, 23'($urandom_range(0, 1)));
			write_cfg(dmsr_pkg::REG_ACCEL_TIME,
				23'((s == 5) ? 32'hFFFF : $urandom_range(1, 6)));
			write_cfg(dmsr_pkg::REG_DECEL_TIME,
				23'((s == 4) ? 32'hFFFF : $urandom_range(1, 6)));
			write_cfg(dmsr_pkg::REG_GEAR_TIME,
				23'((s == 3) ? 32'd0 : $urandom_range(1, 6)));
			write_cfg(dmsr_pkg::REG_MIN_STOP,
				23'((s == 2) ? 32'hFFFF : $urandom_range(0, 4)));
			write_cfg(dmsr_pkg::REG_BUMPER,
				23'((s == 1) ? 32'h7FFFFF : $urandom_range(0, 8000)));
			write_cfg(dmsr_pkg::REG_FULL_SCALE, 23'((s == 0) ? 32'h7FFFFF :
				(s == 4) ? 32'd0 : $urandom_range(1, 8388607)));
			@(negedge clk);
			random_phase(160);
		end
		drain();

		$display("sent %0d tick items, checked %0d command items over six register settings",
			ticks_sent, results_seen);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb_dual_motor_speed_ramp: clean");
		else
			$display("tb_dual_motor_speed_ramp: errors");
		$finish;
	end
endmodule
